/* rtl/core/dhcs_pkg.sv */
package dhcs_pkg;

	// Field widths
	localparam int CYL_W     = 16;
	localparam int MOVE_W    = 18;
	localparam int DISK_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 40;   // visit_cylinder + movement_so_far, padded to bytes

	localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

	// Default store capacity
	localparam int MAX_REQUESTS_DEF = 32;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 2'd0,
		REG_SWEEP = 2'd1,
		REG_HEAD  = 2'd2,
		REG_DISK  = 2'd3
	} dhcs_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SPLIT,
		ST_RUN_A,
		ST_EDGE_1,
		ST_EDGE_2,
		ST_RUN_B
	} dhcs_state_t;

	// Insert command broadcast along the row of cells
	typedef struct packed {
		logic             ins;
		logic [CYL_W-1:0] cyl;
	} dhcs_ins_t;

endpackage

/* rtl/core/dhcs_cell.sv */
module dhcs_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  logic                        clk,
	input  dhcs_pkg::dhcs_ins_t         ins,
	input  logic [CW-1:0]               count,
	input  logic [dhcs_pkg::CYL_W-1:0]  head,
	input  logic                        prev_gt,
	input  logic [dhcs_pkg::CYL_W-1:0]  prev_val,
	input  logic                        prev_above,
	output logic                        gt,
	output logic [dhcs_pkg::CYL_W-1:0]  val,
	output logic                        above,
	output logic                        first
);

	logic                       occ;
	logic [dhcs_pkg::CYL_W-1:0] val_q;

	assign occ = count > CW'(IDX);
	assign val = val_q;

	// An empty cell acts as larger than any request
	assign gt = !occ || (val_q > ins.cyl);

	// Split flags: first occupied entry strictly above the head
	assign above = occ && (val_q > head);
	assign first = above && !prev_above;

	// Shift up from the left neighbor, or take the new request at the gap
	always_ff @(posedge clk) begin
		if (ins.ins && gt) begin
			val_q <= prev_gt ? prev_val : ins.cyl;
		end
	end

endmodule

/* rtl/core/dhcs_chain.sv */
module dhcs_chain #(
	parameter int MAX_REQUESTS = dhcs_pkg::MAX_REQUESTS_DEF,
	parameter int CW = $clog2(MAX_REQUESTS + 1),
	parameter int IW = $clog2(MAX_REQUESTS)
) (
	input  logic                        clk,
	input  dhcs_pkg::dhcs_ins_t         ins,
	input  logic [CW-1:0]               count,
	input  logic [dhcs_pkg::CYL_W-1:0]  head,
	input  logic [IW-1:0]               rd_idx,
	output logic [dhcs_pkg::CYL_W-1:0]  rd_val,
	output logic [CW-1:0]               split
);

	logic                       gt_w    [MAX_REQUESTS];
	logic [dhcs_pkg::CYL_W-1:0] val_w   [MAX_REQUESTS];
	logic                       above_w [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0]    first_w;

	// Row of cells, each fed by its left neighbor
	for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			dhcs_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk        (clk),
				.ins        (ins),
				.count      (count),
				.head       (head),
				.prev_gt    (1'b0),
				.prev_val   ('0),
				.prev_above (1'b0),
				.gt         (gt_w[i]),
				.val        (val_w[i]),
				.above      (above_w[i]),
				.first      (first_w[i])
			);
		end else begin : g_body
			dhcs_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk        (clk),
				.ins        (ins),
				.count      (count),
				.head       (head),
				.prev_gt    (gt_w[i-1]),
				.prev_val   (val_w[i-1]),
				.prev_above (above_w[i-1]),
				.gt         (gt_w[i]),
				.val        (val_w[i]),
				.above      (above_w[i]),
				.first      (first_w[i])
			);
		end
	end

	// Encode the single split marker; none means the end of the store
	always_comb begin
		logic [CW-1:0] enc;
		enc = '0;
		for (int i = 0; i < MAX_REQUESTS; i++) begin
			enc = enc | (first_w[i] ? CW'(i) : '0);
		end
		split = (|first_w) ? enc : count;
	end

	// Read port for emission
	assign rd_val = val_w[rd_idx];

endmodule

/* rtl/core/disk_head_cscan_clook_scheduler.sv */
// C-SCAN / C-LOOK disk head scheduler.
//
// Requests enter on the s_axis channel, one cylinder per transfer; they are
// kept sorted in a row of cells that takes one request per cycle. A transfer
// with tlast closes the batch: s_axis_tready drops, the ST_SPLIT state finds the
// split point around start_head, and from then on one visit per cycle leaves
// on the m_axis channel whenever m_axis_tready lets the output register move.
// A batch of n requests gives n visits, plus edge visits at both ends under C-SCAN;
// the final visit carries tlast and its movement is the batch total. Requests
// beyond MAX_REQUESTS are dropped. After the final visit is loaded into the
// output register the store is empty and s_axis_tready returns.
// The output register holds a visit while m_axis_tready is low and the
// emission sequencer waits on it; nothing is lost or repeated.
// Configuration writes on the cfg channel are always ready and take effect
// at the next batch closure. Reset clears the store count, the sequencer and
// the output valid, and loads the register defaults (C-SCAN, sweep up, head
// at cylinder 0, 65536 cylinders). No clearing pass is needed.
module disk_head_cscan_clook_scheduler #(
	parameter int MAX_REQUESTS = dhcs_pkg::MAX_REQUESTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [15:0]                         s_axis_tdata,  // [15:0] request_cylinder
	input  logic                                s_axis_tlast,  // last_request
	// Visit stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [dhcs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [15:0] visit_cylinder,
	                                                           // [33:16] movement_so_far
	output logic                                m_axis_tuser,  // edge_visit
	output logic                                m_axis_tlast,  // last_in_run
	// Configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dhcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dhcs_pkg::DISK_W-1:0]         cfg_data
);

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int IW = $clog2(MAX_REQUESTS);
	localparam int CYL_W = dhcs_pkg::CYL_W;
	localparam int MOVE_W = dhcs_pkg::MOVE_W;

	// Configuration registers
	logic                          mode_q;
	logic                          sweep_q;
	logic [CYL_W-1:0]              head_q;
	logic [dhcs_pkg::DISK_W-1:0]   disk_q;

	// Control state
	dhcs_pkg::dhcs_state_t state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [IW-1:0]         ptr_q, ptr_d;
	logic [CW-1:0]         split_q;
	logic                  up_q;
	logic                  cscan_q;
	logic [CYL_W-1:0]      top_q;
	logic [CYL_W-1:0]      pos_q;
	logic [MOVE_W-1:0]     mv_q;
	logic                  ov_q;

	// Output payload
	logic [CYL_W-1:0]      ocyl_q;
	logic [MOVE_W-1:0]     omv_q;
	logic                  oedge_q;
	logic                  olast_q;

	dhcs_pkg::dhcs_ins_t   ins_w;
	logic [CYL_W-1:0]      rd_val_w;
	logic [CW-1:0]         split_w;
	logic                  in_acc;
	logic                  adv;
	logic                  start;
	logic                  emit_st;
	logic [CYL_W-1:0]      vis_cyl;
	logic                  vis_edge;
	logic                  vis_last;
	logic [CYL_W-1:0]      hop;
	logic [MOVE_W:0]       sum_w;
	logic [MOVE_W-1:0]     mv_new;
	logic [CYL_W-1:0]      top_w;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == dhcs_pkg::ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Insert only while the store has room
	assign ins_w.ins = in_acc && (count_q < CW'(MAX_REQUESTS));
	assign ins_w.cyl = s_axis_tdata[CYL_W-1:0];

	dhcs_chain #(.MAX_REQUESTS(MAX_REQUESTS), .CW(CW), .IW(IW)) u_chain (
		.clk    (clk),
		.ins    (ins_w),
		.count  (count_q),
		.head   (head_q),
		.rd_idx (ptr_q),
		.rd_val (rd_val_w),
		.split  (split_w)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			sweep_q <= 1'b1;
			head_q  <= '0;
			disk_q  <= 17'h10000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dhcs_pkg::dhcs_reg_t'(cfg_index))
				dhcs_pkg::REG_MODE:  mode_q  <= cfg_data[0];
				dhcs_pkg::REG_SWEEP: sweep_q <= cfg_data[0];
				dhcs_pkg::REG_HEAD:  head_q  <= cfg_data[CYL_W-1:0];
				dhcs_pkg::REG_DISK:  disk_q  <= cfg_data;
			endcase
		end
	end

	// Top cylinder, with out-of-range disk sizes clamped
	always_comb begin
		if (disk_q == '0) begin
			top_w = '0;
		end else if (disk_q[dhcs_pkg::DISK_W-1]) begin
			top_w = '1;
		end else begin
			top_w = disk_q[CYL_W-1:0] - CYL_W'(1);
		end
	end

	assign emit_st = (state_q == dhcs_pkg::ST_RUN_A) || (state_q == dhcs_pkg::ST_EDGE_1) ||
	                 (state_q == dhcs_pkg::ST_EDGE_2) || (state_q == dhcs_pkg::ST_RUN_B);
	assign adv     = emit_st && (!ov_q || m_axis_tready);
	assign start   = (state_q == dhcs_pkg::ST_SPLIT);

	// Next state, read pointer and the visit to emit
	always_comb begin
		logic [CW-1:0] ptr_ext;
		logic [CW-1:0] cnt_m1;
		logic          has_a;
		logic          has_b;
		logic          end_a;
		logic          end_b;
		logic [IW-1:0] ptr_step;
		logic [IW-1:0] b_init;
		ptr_ext  = CW'(ptr_q);
		cnt_m1   = count_q - CW'(1);
		has_b    = up_q ? (split_q != '0) : (split_q != count_q);
		end_a    = up_q ? (ptr_ext == cnt_m1) : (ptr_q == '0);
		end_b    = up_q ? (ptr_ext == split_q - CW'(1)) : (ptr_ext == split_q);
		ptr_step = up_q ? ptr_q + IW'(1) : ptr_q - IW'(1);
		b_init   = up_q ? '0 : cnt_m1[IW-1:0];
		has_a    = sweep_q ? (split_w != count_q) : (split_w != '0);

		state_d  = state_q;
		ptr_d    = ptr_q;
		count_d  = count_q;
		vis_cyl  = rd_val_w;
		vis_edge = 1'b0;
		vis_last = 1'b0;

		if (ins_w.ins) begin
			count_d = count_q + CW'(1);
		end

		unique case (state_q)
			dhcs_pkg::ST_LOAD: begin
				if (in_acc && s_axis_tlast) begin
					state_d = dhcs_pkg::ST_SPLIT;
				end
			end
			dhcs_pkg::ST_SPLIT: begin
				// Pick the first phase from the fresh split point
				if (has_a) begin
					state_d = dhcs_pkg::ST_RUN_A;
					ptr_d   = sweep_q ? split_w[IW-1:0] : IW'(split_w - CW'(1));
				end else if (!mode_q) begin
					state_d = dhcs_pkg::ST_EDGE_1;
				end else begin
					state_d = dhcs_pkg::ST_RUN_B;
					ptr_d   = sweep_q ? '0 : IW'(count_q - CW'(1));
				end
			end
			dhcs_pkg::ST_RUN_A: begin
				if (adv) begin
					if (!end_a) begin
						ptr_d = ptr_step;
					end else if (cscan_q) begin
						state_d = dhcs_pkg::ST_EDGE_1;
					end else if (has_b) begin
						state_d = dhcs_pkg::ST_RUN_B;
						ptr_d   = b_init;
					end else begin
						vis_last = 1'b1;
					end
				end
			end
			dhcs_pkg::ST_EDGE_1: begin
				vis_cyl  = up_q ? top_q : '0;
				vis_edge = 1'b1;
				if (adv) begin
					state_d = dhcs_pkg::ST_EDGE_2;
				end
			end
			dhcs_pkg::ST_EDGE_2: begin
				vis_cyl  = up_q ? '0 : top_q;
				vis_edge = 1'b1;
				if (adv) begin
					if (has_b) begin
						state_d = dhcs_pkg::ST_RUN_B;
						ptr_d   = b_init;
					end else begin
						vis_last = 1'b1;
					end
				end
			end
			dhcs_pkg::ST_RUN_B: begin
				if (adv) begin
					if (end_b) begin
						vis_last = 1'b1;
					end else begin
						ptr_d = ptr_step;
					end
				end
			end
			default: begin
				state_d = dhcs_pkg::ST_LOAD;
			end
		endcase

		// Close the batch and empty the store
		if (vis_last) begin
			state_d = dhcs_pkg::ST_LOAD;
			count_d = '0;
		end
	end

	// Head movement for this visit, saturating
	assign hop    = (vis_cyl > pos_q) ? (vis_cyl - pos_q) : (pos_q - vis_cyl);
	assign sum_w  = {1'b0, mv_q} + (MOVE_W + 1)'(hop);
	assign mv_new = sum_w[MOVE_W] ? dhcs_pkg::MOVE_MAX : sum_w[MOVE_W-1:0];

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhcs_pkg::ST_LOAD;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (adv) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Batch context, head tracking and pointer
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (start) begin
			split_q <= split_w;
			up_q    <= sweep_q;
			cscan_q <= !mode_q;
			top_q   <= top_w;
			pos_q   <= head_q;
			mv_q    <= '0;
		end else if (adv) begin
			pos_q <= vis_cyl;
			mv_q  <= mv_new;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ocyl_q  <= vis_cyl;
			omv_q   <= mv_new;
			oedge_q <= vis_edge;
			olast_q <= vis_last;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {{(dhcs_pkg::OUT_DATA_W - MOVE_W - CYL_W){1'b0}}, omv_q, ocyl_q};
	assign m_axis_tuser  = oedge_q;
	assign m_axis_tlast  = olast_q;

	// Store count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REQUESTS))
		else $error("request count above capacity");

	// Edge visits only come out of a C-SCAN batch
	a_edge_cscan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> cscan_q)
		else $error("edge visit outside C-SCAN");

	// Movement never shrinks within a batch
	a_move_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		!m_axis_tvalid || (m_axis_tdata[33:16] >= $past(m_axis_tdata[33:16])))
		else $error("movement decreased within a batch");

endmodule
